@@ rtl/core/efla_pkg.sv @@
// ----------------------------------------------------------------------------
// efla_pkg
// Shared types, codes and widths for the extent free-list allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package efla_pkg;

  // Fixed field widths
  localparam int OFFSET_W  = 40;
  localparam int PAGE_W    = 21;
  localparam int COUNT_W   = 11;
  localparam int STATUS_W  = 3;
  localparam int ALLOC_W   = 31;
  localparam int USED_W    = 11;
  localparam int CFG_IDX_W = 2;

  // Default built depth
  localparam int MAX_EXTENTS_DEF = 1024;

  // Reset values of the config registers
  localparam logic [PAGE_W-1:0]  PAGE_SIZE_RST    = PAGE_W'(4096);
  localparam logic [COUNT_W-1:0] EXTENT_COUNT_RST = COUNT_W'(1024);

  // Restoring divider: one quotient bit per cycle
  localparam int DIV_STEPS = OFFSET_W;
  localparam int DIV_CNT_W = $clog2(DIV_STEPS);

  // Config register indexes
  localparam logic [CFG_IDX_W-1:0] REG_PAGE_SIZE    = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_EXTENT_COUNT = CFG_IDX_W'(1);

  typedef enum logic [1:0] {
    CMD_ALLOC = 2'd0,
    CMD_FREE  = 2'd1,
    CMD_OPEN  = 2'd2,
    CMD_CLOSE = 2'd3
  } command_t;

  typedef enum logic [STATUS_W-1:0] {
    STAT_OK          = 3'd0,
    STAT_NO_SPACE    = 3'd1,
    STAT_NOT_OPEN    = 3'd2,
    STAT_BAD_OFFSET  = 3'd3,
    STAT_DOUBLE_FREE = 3'd4
  } status_t;

  // Controller -> datapath
  typedef struct packed {
    logic    open_start;
    logic    sweep;
    logic    open_done;
    logic    close;
    logic    pop;
    logic    alloc_mark;
    logic    div_start;
    logic    div_step;
    logic    map_read;
    logic    free_commit;
    logic    emit;
    logic    res_alloc;
    status_t res_status;
  } efla_cmd_t;

  // Datapath -> controller
  typedef struct packed {
    logic is_open;
    logic stack_empty;
    logic sweep_last;
    logic div_last;
    logic free_bad;
    logic map_bit;
    logic out_full;
  } efla_stat_t;

endpackage

`default_nettype wire

@@ rtl/core/extent_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// extent_free_list_allocator
// Fixed-size extent allocator with a LIFO free stack and a used bitmap.
// ----------------------------------------------------------------------------
// One command word in, one result word out. Close goes straight to the result
// stage, and an allocate reads the stack, then multiplies (index+1) by the
// page size. A free divides the offset by the page size in a restoring divider
// that yields one quotient bit per cycle over all 40 offset bits, followed by
// the range check, a used-map read and the push; a rejected offset skips the
// read and the push. Allocate or free on a closed store goes straight to the
// result stage. Open sweeps every entry of both memories, refilling the free
// stack and clearing the used map. A new word is taken as soon as the
// sequencer is back in idle, even while the previous result still sits in the
// output register. Config writes are always ready and only take effect at
// the next open.
`default_nettype none

module extent_free_list_allocator
  import efla_pkg::*;
#(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  output logic                      cfg_ready,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PAGE_W-1:0]    cfg_data,
  input  wire logic                 in_valid,
  output logic                      in_stall,
  input  wire logic [1:0]           command,
  input  wire logic [OFFSET_W-1:0]  offset,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [STATUS_W-1:0]       status,
  output logic [ALLOC_W-1:0]        alloc_offset,
  output logic [USED_W-1:0]         used_count
);

  efla_cmd_t  cmd;
  efla_stat_t stat;

  assign cfg_ready = 1'b1;

  efla_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .command  (command),
    .stat     (stat),
    .cmd      (cmd)
  );

  efla_dp #(
    .MAX_EXTENTS (MAX_EXTENTS)
  ) u_dp (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid && cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .offset       (offset),
    .cmd          (cmd),
    .stat         (stat),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .alloc_offset (alloc_offset),
    .used_count   (used_count)
  );

endmodule

`default_nettype wire

@@ rtl/core/efla_ctrl.sv @@
// ----------------------------------------------------------------------------
// efla_ctrl
// Command sequencer: decodes each word and steps the datapath through it.
// ----------------------------------------------------------------------------
`default_nettype none

module efla_ctrl
  import efla_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [1:0] command,
  input  efla_stat_t      stat,
  output efla_cmd_t       cmd
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_ALLOC,
    S_DIV,
    S_CHECK,
    S_READ,
    S_RESULT
  } state_t;

  state_t   state;
  status_t  res_code;
  logic     res_alloc;
  logic     accept;
  command_t cmd_in;

  assign cmd_in   = command_t'(command);
  assign in_stall = (state != S_IDLE);
  assign accept   = in_valid && (state == S_IDLE);

  // State and result code
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      res_code  <= STAT_OK;
      res_alloc <= 1'b0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            res_alloc <= 1'b0;
            res_code  <= STAT_OK;
            case (cmd_in)
              CMD_ALLOC: begin
                if (!stat.is_open) begin
                  res_code <= STAT_NOT_OPEN;
                  state    <= S_RESULT;
                end else if (stat.stack_empty) begin
                  res_code <= STAT_NO_SPACE;
                  state    <= S_RESULT;
                end else begin
                  res_alloc <= 1'b1;
                  state     <= S_ALLOC;
                end
              end
              CMD_FREE: begin
                if (!stat.is_open) begin
                  res_code <= STAT_NOT_OPEN;
                  state    <= S_RESULT;
                end else begin
                  state <= S_DIV;
                end
              end
              CMD_OPEN: state <= S_SWEEP;
              default:  state <= S_RESULT;
            endcase
          end
        end
        S_SWEEP: if (stat.sweep_last) state <= S_RESULT;
        S_ALLOC: state <= S_RESULT;
        S_DIV:   if (stat.div_last) state <= S_CHECK;
        S_CHECK: begin
          if (stat.free_bad) begin
            res_code <= STAT_BAD_OFFSET;
            state    <= S_RESULT;
          end else begin
            state <= S_READ;
          end
        end
        S_READ: begin
          res_code <= stat.map_bit ? STAT_OK : STAT_DOUBLE_FREE;
          state    <= S_RESULT;
        end
        S_RESULT: if (!stat.out_full) state <= S_IDLE;
        default:  state <= S_IDLE;
      endcase
    end
  end

  // Datapath commands
  always_comb begin
    cmd            = '0;
    cmd.res_status = res_code;
    cmd.res_alloc  = res_alloc;
    case (state)
      S_IDLE: begin
        if (accept) begin
          case (cmd_in)
            CMD_ALLOC: cmd.pop        = stat.is_open && !stat.stack_empty;
            CMD_FREE:  cmd.div_start  = stat.is_open;
            CMD_OPEN:  cmd.open_start = 1'b1;
            default:   cmd.close      = 1'b1;
          endcase
        end
      end
      S_SWEEP: begin
        cmd.sweep     = 1'b1;
        cmd.open_done = stat.sweep_last;
      end
      S_ALLOC:  cmd.alloc_mark  = 1'b1;
      S_DIV:    cmd.div_step    = 1'b1;
      S_CHECK:  cmd.map_read    = !stat.free_bad;
      S_READ:   cmd.free_commit = stat.map_bit;
      S_RESULT: cmd.emit        = !stat.out_full;
      default:  ;
    endcase
  end

endmodule

`default_nettype wire

@@ rtl/core/efla_dp.sv @@
// ----------------------------------------------------------------------------
// efla_dp
// Datapath: config registers, free stack and used map memories, divider,
// offset multiplier and result register.
// ----------------------------------------------------------------------------
`default_nettype none

module efla_dp
  import efla_pkg::*;
#(
  parameter int MAX_EXTENTS = MAX_EXTENTS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 cfg_valid,
  input  wire logic [CFG_IDX_W-1:0] cfg_index,
  input  wire logic [PAGE_W-1:0]    cfg_data,
  input  wire logic [OFFSET_W-1:0]  offset,
  input  efla_cmd_t                 cmd,
  output efla_stat_t                stat,
  output logic                      out_valid,
  input  wire logic                 out_stall,
  output logic [STATUS_W-1:0]       status,
  output logic [ALLOC_W-1:0]        alloc_offset,
  output logic [USED_W-1:0]         used_count
);

  localparam int IDX_W  = (MAX_EXTENTS > 1) ? $clog2(MAX_EXTENTS) : 1;
  localparam int CNT_W  = $clog2(MAX_EXTENTS + 1);
  localparam int PROD_W = (CNT_W + PAGE_W > ALLOC_W) ? CNT_W + PAGE_W : ALLOC_W;

  // Config and values latched at open
  logic [PAGE_W-1:0]  page_cfg;
  logic [COUNT_W-1:0] count_cfg;
  logic [PAGE_W-1:0]  open_page;
  logic [CNT_W-1:0]   open_count;
  logic [CNT_W-1:0]   count_clamp;

  // Control state
  logic             is_open;
  logic [CNT_W-1:0] depth;
  logic [CNT_W-1:0] used;
  logic [IDX_W-1:0] sweep_cnt;

  // Memories
  logic [IDX_W-1:0] free_stack [MAX_EXTENTS];
  logic             used_map   [MAX_EXTENTS];
  logic [IDX_W-1:0] stack_rd;
  logic             map_rd;
  logic [IDX_W-1:0] pop_addr;
  logic [CNT_W-1:0] depth_m1;

  // Divider
  logic [OFFSET_W-1:0]  dvd;
  logic [PAGE_W-1:0]    rem;
  logic [DIV_CNT_W-1:0] div_cnt;
  logic [PAGE_W:0]      shifted;
  logic [PAGE_W:0]      diff;
  logic [OFFSET_W-1:0]  quot_m1;
  logic [IDX_W-1:0]     free_idx;

  // Multiplier
  logic [CNT_W-1:0]   idx_plus;
  logic [PROD_W-1:0]  prod;
  logic [ALLOC_W-1:0] mul_q;

  // Config writes
  always_ff @(posedge clk) begin
    if (rst) begin
      page_cfg  <= PAGE_SIZE_RST;
      count_cfg <= EXTENT_COUNT_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_PAGE_SIZE:    page_cfg  <= cfg_data;
        REG_EXTENT_COUNT: count_cfg <= cfg_data[COUNT_W-1:0];
        default:          ;
      endcase
    end
  end

  assign count_clamp = (32'(count_cfg) > 32'(MAX_EXTENTS)) ? CNT_W'(MAX_EXTENTS)
                                                           : CNT_W'(count_cfg);

  // Open parameters and sweep counter
  always_ff @(posedge clk) begin
    if (cmd.open_start) begin
      open_page  <= (page_cfg == '0) ? PAGE_W'(1) : page_cfg;
      open_count <= count_clamp;
      sweep_cnt  <= '0;
    end else if (cmd.sweep) begin
      sweep_cnt  <= sweep_cnt + IDX_W'(1);
    end
  end

  assign depth_m1 = depth - CNT_W'(1);
  assign pop_addr = depth_m1[IDX_W-1:0];

  // Stack depth, used counter, open flag
  always_ff @(posedge clk) begin
    if (rst) begin
      is_open <= 1'b0;
      depth   <= '0;
      used    <= '0;
    end else if (cmd.open_start || cmd.close) begin
      is_open <= 1'b0;
      depth   <= '0;
      used    <= '0;
    end else if (cmd.open_done) begin
      is_open <= 1'b1;
      depth   <= open_count;
    end else if (cmd.pop) begin
      depth   <= depth_m1;
    end else if (cmd.alloc_mark) begin
      used    <= used + CNT_W'(1);
    end else if (cmd.free_commit) begin
      if (used != '0) used <= used - CNT_W'(1);
      if (32'(depth) < 32'(MAX_EXTENTS)) depth <= depth + CNT_W'(1);
    end
  end

  // Free stack memory
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      free_stack[sweep_cnt] <= sweep_cnt;
    end else if (cmd.free_commit && (32'(depth) < 32'(MAX_EXTENTS))) begin
      free_stack[depth[IDX_W-1:0]] <= free_idx;
    end
    if (cmd.pop) stack_rd <= free_stack[pop_addr];
  end

  // Used map memory
  always_ff @(posedge clk) begin
    if (cmd.sweep) begin
      used_map[sweep_cnt] <= 1'b0;
    end else if (cmd.alloc_mark) begin
      used_map[stack_rd] <= 1'b1;
    end else if (cmd.free_commit) begin
      used_map[free_idx] <= 1'b0;
    end
    if (cmd.map_read) map_rd <= used_map[free_idx];
  end

  // Restoring divider: offset / page size, one bit per cycle
  assign shifted = {rem, dvd[OFFSET_W-1]};
  assign diff    = shifted - {1'b0, open_page};

  always_ff @(posedge clk) begin
    if (cmd.div_start) begin
      dvd     <= offset;
      rem     <= '0;
      div_cnt <= '0;
    end else if (cmd.div_step) begin
      div_cnt <= div_cnt + DIV_CNT_W'(1);
      if (!diff[PAGE_W]) begin
        rem <= diff[PAGE_W-1:0];
        dvd <= {dvd[OFFSET_W-2:0], 1'b1};
      end else begin
        rem <= shifted[PAGE_W-1:0];
        dvd <= {dvd[OFFSET_W-2:0], 1'b0};
      end
    end
  end

  assign quot_m1  = dvd - OFFSET_W'(1);
  assign free_idx = quot_m1[IDX_W-1:0];

  // Allocated offset: (index + 1) * page size
  assign idx_plus = CNT_W'(stack_rd) + CNT_W'(1);
  assign prod     = PROD_W'(idx_plus) * PROD_W'(open_page);

  always_ff @(posedge clk) begin
    if (cmd.alloc_mark) mul_q <= prod[ALLOC_W-1:0];
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.emit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      status       <= cmd.res_status;
      alloc_offset <= cmd.res_alloc ? mul_q : '0;
      used_count   <= is_open ? USED_W'(used) : '0;
    end
  end

  // Status to controller
  always_comb begin
    stat             = '0;
    stat.is_open     = is_open;
    stat.stack_empty = (depth == '0);
    stat.sweep_last  = (sweep_cnt == IDX_W'(MAX_EXTENTS - 1));
    stat.div_last    = (div_cnt == DIV_CNT_W'(DIV_STEPS - 1));
    stat.free_bad    = (rem != '0) || (dvd == '0) || (dvd > OFFSET_W'(open_count));
    stat.map_bit     = map_rd;
    stat.out_full    = out_valid && out_stall;
  end

endmodule

`default_nettype wire

@@ tb/tb_extent_free_list_allocator.sv @@
// ----------------------------------------------------------------------------
// tb_extent_free_list_allocator
// Self-checking bench for the LIFO extent allocator. A clocked driver feeds
// command words from a queue, a clocked monitor checks every result word
// against an in-bench model of the free stack, used map and used counter.
// Directed words hit the corner cases first, then random phases run under
// several page size / extent count settings with random idling on both sides.
// ----------------------------------------------------------------------------
module tb_extent_free_list_allocator
  import efla_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int NX          = MAX_EXTENTS_DEF;
  localparam int STALL_LIMIT = 20000;
  localparam int HOLD_CYCLES = 400;

  // indexes with no register behind them
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_2 = CFG_IDX_W'(2);
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_3 = CFG_IDX_W'(3);

  typedef struct {
    command_t            cmd;
    logic [OFFSET_W-1:0] off;
  } cmd_word_t;

  typedef struct {
    status_t            st;
    logic [ALLOC_W-1:0] alloc;
    logic [USED_W-1:0]  used;
  } reply_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [PAGE_W-1:0]    cfg_data = '0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           command = CMD_ALLOC;
  logic [OFFSET_W-1:0]  offset = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [STATUS_W-1:0]  status;
  logic [ALLOC_W-1:0]   alloc_offset;
  logic [USED_W-1:0]    used_count;

  extent_free_list_allocator DUT (
    .clk          (clk),
    .rst          (rst),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .command      (command),
    .offset       (offset),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .status       (status),
    .alloc_offset (alloc_offset),
    .used_count   (used_count)
  );

  always #10 clk = ~clk;

  // Allocator model state
  logic [PAGE_W-1:0]  reg_page  = PAGE_SIZE_RST;
  logic [COUNT_W-1:0] reg_count = EXTENT_COUNT_RST;
  logic [9:0]         stk [NX];
  bit                 used_bits [NX];
  int unsigned        stk_depth = 0;
  int unsigned        used_tot = 0;
  int unsigned        lat_count = 0;
  longint unsigned    lat_page = 0;
  bit                 store_open = 1'b0;

  cmd_word_t cmd_q [$];
  reply_t    reply_q [$];
  cmd_word_t tx_word;

  // Handshake / idling state
  bit word_taken = 1'b0;
  bit calm = 1'b0;
  bit hold_req = 1'b0;
  int tx_gap = 0;
  int rx_gap = 0;
  int hold_left = 0;
  int idle_cycles = 0;

  // Bookkeeping
  int errors = 0;
  int n_results = 0;
  int n_settings = 0;
  int cmd_seen [4];
  int stat_seen [8];

  task report_err(input string msg);
    errors++;
    if (errors <= 10) $display("%0t mismatch: %s", $time, msg);
  endtask

  // Drop everything: closed store, empty stack, clear map
  task shut_store();
    for (int i = 0; i < NX; i++) used_bits[i] = 1'b0;
    stk_depth  = 0;
    used_tot   = 0;
    store_open = 1'b0;
    lat_page   = 0;
    lat_count  = 0;
  endtask

  // Run one command on the model and queue the reply it must produce
  task alloc_step(input command_t c, input logic [OFFSET_W-1:0] off);
    status_t         st;
    longint unsigned a, top, idx, o;
    reply_t          r;
    st = STAT_OK;
    a  = 0;
    o  = off;
    case (c)
      CMD_ALLOC: begin
        if (!store_open) begin
          st = STAT_NOT_OPEN;
        end else if (stk_depth == 0) begin
          st = STAT_NO_SPACE;
        end else begin
          stk_depth--;
          idx = stk[stk_depth];
          used_bits[idx] = 1'b1;
          used_tot++;
          a = (idx + 1) * lat_page;
        end
      end
      CMD_FREE: begin
        if (!store_open) begin
          st = STAT_NOT_OPEN;
        end else begin
          top = (longint'(lat_count) + 1) * lat_page;
          if (o % lat_page != 0 || o < lat_page || o >= top) begin
            st = STAT_BAD_OFFSET;
          end else begin
            idx = o / lat_page - 1;
            if (idx >= lat_count) begin
              st = STAT_BAD_OFFSET;
            end else if (!used_bits[idx]) begin
              st = STAT_DOUBLE_FREE;
            end else begin
              used_bits[idx] = 1'b0;
              if (used_tot != 0) used_tot--;
              if (stk_depth < NX) begin
                stk[stk_depth] = idx[9:0];
                stk_depth++;
              end
            end
          end
        end
      end
      CMD_OPEN: begin
        shut_store();
        lat_page  = (reg_page == 0) ? 1 : reg_page;
        lat_count = (reg_count > NX) ? NX : reg_count;
        for (int i = 0; i < lat_count; i++) stk[i] = i[9:0];
        stk_depth  = lat_count;
        store_open = 1'b1;
      end
      default: shut_store();
    endcase
    r.st    = st;
    r.alloc = a[ALLOC_W-1:0];
    r.used  = store_open ? USED_W'(used_tot) : '0;
    reply_q = {reply_q, r};
  endtask

  // Input acceptance, model update, result check, watchdog
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && !in_stall) begin
        word_taken = 1'b1;
        cmd_seen[command]++;
        alloc_step(command_t'(command), offset);
      end
      if (out_valid && !out_stall) begin
        n_results++;
        stat_seen[status]++;
        if (reply_q.size() == 0) begin
          report_err($sformatf("result %0d arrived with nothing expected", n_results));
        end else begin
          reply_t exp_r;
          exp_r = reply_q[0];
          reply_q.delete(0);
          if (status !== exp_r.st || alloc_offset !== exp_r.alloc ||
              used_count !== exp_r.used)
            report_err($sformatf(
              "result %0d exp st=%0d off=%0h used=%0d got st=%0d off=%0h used=%0d",
              n_results, exp_r.st, exp_r.alloc, exp_r.used,
              status, alloc_offset, used_count));
        end
      end
    end
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles = 0;
    else
      idle_cycles++;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("timeout: no handshake for %0d cycles", STALL_LIMIT);
      $display("[extent_free_list_allocator] ERROR");
      $finish;
    end
  end

  // Command driver: holds a word until taken, random gaps between words
  always @(negedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || word_taken) begin
      word_taken = 1'b0;
      if (tx_gap > 0) begin
        tx_gap--;
        in_valid <= 1'b0;
      end else if (cmd_q.size() > 0) begin
        tx_word = cmd_q[0];
        cmd_q.delete(0);
        command  <= tx_word.cmd;
        offset   <= tx_word.off;
        in_valid <= 1'b1;
        if (!calm && $urandom_range(0, 4) == 0) tx_gap = $urandom_range(1, 5);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result-side stall: random bursts plus one long hold-off on request
  always @(negedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else if (rx_gap > 0) begin
        rx_gap--;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 7) == 0) begin
        rx_gap = $urandom_range(0, 4);
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  // Wait until every word is taken and every reply has come back; checked
  // just after the falling edge so the driver's update is already visible
  task wait_idle();
    do begin
      @(negedge clk);
      #1;
    end while (cmd_q.size() != 0 || in_valid || reply_q.size() != 0);
  endtask

  // Called just after a falling edge, returns at a falling edge with cfg_valid still up
  task write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [PAGE_W-1:0] d);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= d;
    do @(posedge clk);
    while (!cfg_ready);
    if (idx == REG_PAGE_SIZE) reg_page = d;
    else if (idx == REG_EXTENT_COUNT) reg_count = d[COUNT_W-1:0];
    n_settings++;
    @(negedge clk);
  endtask

  task push_word(input command_t c, input logic [OFFSET_W-1:0] off);
    cmd_word_t w;
    w.cmd = c;
    w.off = off;
    while (cmd_q.size() >= 2) @(negedge clk);
    cmd_q = {cmd_q, w};
  endtask

  // Free offsets: mostly live extents, some free ones, some malformed
  function automatic logic [OFFSET_W-1:0] pick_free_offset();
    int unsigned     k, start, r;
    logic [63:0]     rnd;
    longint unsigned o;
    rnd = {$urandom, $urandom};
    if (!store_open || lat_count == 0)
      return rnd[0] ? OFFSET_W'(lat_page) : rnd[OFFSET_W-1:0];
    r = $urandom_range(0, 99);
    if (r < 70) begin
      start = $urandom_range(0, lat_count - 1);
      for (k = 0; k < lat_count; k++)
        if (used_bits[(start + k) % lat_count])
          return OFFSET_W'((longint'((start + k) % lat_count) + 1) * lat_page);
    end
    k = $urandom_range(0, lat_count - 1);
    if (r < 85) return OFFSET_W'((longint'(k) + 1) * lat_page);
    case ($urandom_range(0, 3))
      0: o = $urandom_range(0, int'(lat_page) - 1);  // inside header page
      1: o = (lat_page > 1) ?
             (longint'(k) + 1) * lat_page + $urandom_range(1, int'(lat_page) - 1) :
             (longint'(lat_count) + 1) * lat_page;
      2: o = (longint'(lat_count) + 1 + $urandom_range(0, 3)) * lat_page;
      default: o = rnd;
    endcase
    return o[OFFSET_W-1:0];
  endfunction

  task gen_random_word();
    int unsigned          r;
    command_t             c;
    logic [63:0]          rnd;
    logic [OFFSET_W-1:0]  off;
    r   = $urandom_range(0, 999);
    rnd = {$urandom, $urandom};
    if (!store_open && $urandom_range(0, 3) == 0) c = CMD_OPEN;
    else if (r < 15) c = CMD_OPEN;
    else if (r < 25) c = CMD_CLOSE;
    else if (r < 500) c = CMD_ALLOC;
    else c = CMD_FREE;
    off = (c == CMD_FREE) ? pick_free_offset() : rnd[OFFSET_W-1:0];
    push_word(c, off);
  endtask

  // One setting: program registers while idle, open, then random words
  task run_phase(input logic [PAGE_W-1:0] pg, input logic [PAGE_W-1:0] cnt,
                 input int n, input bit spare, input bit hold_mid, input bit pause_mid);
    wait_idle();
    write_reg(REG_PAGE_SIZE, pg);
    write_reg(REG_EXTENT_COUNT, cnt);
    if (spare) begin
      write_reg(REG_SPARE_2, PAGE_W'($urandom));
      write_reg(REG_SPARE_3, PAGE_W'($urandom));
    end
    cfg_valid <= 1'b0;
    push_word(CMD_OPEN, '0);
    for (int i = 0; i < n; i++) begin
      if (i == n / 2) begin
        if (hold_mid) hold_req = 1'b1;
        if (pause_mid) wait_idle();
      end
      gen_random_word();
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // corner cases under the reset settings
    push_word(CMD_ALLOC, '0);
    push_word(CMD_FREE, '1);
    push_word(CMD_CLOSE, '0);
    push_word(CMD_OPEN, '0);
    push_word(CMD_ALLOC, '0);
    push_word(CMD_ALLOC, '0);
    push_word(CMD_FREE, OFFSET_W'(1024 * 4096));
    push_word(CMD_FREE, OFFSET_W'(1024 * 4096));
    push_word(CMD_FREE, '0);
    push_word(CMD_FREE, OFFSET_W'(4097));
    push_word(CMD_FREE, OFFSET_W'(1025 * 4096));
    push_word(CMD_FREE, '1);
    push_word(CMD_OPEN, '0);
    push_word(CMD_ALLOC, '0);
    push_word(CMD_CLOSE, '0);

    // zero page size and zero extents
    wait_idle();
    write_reg(REG_PAGE_SIZE, '0);
    write_reg(REG_EXTENT_COUNT, '0);
    cfg_valid <= 1'b0;
    push_word(CMD_OPEN, '0);
    push_word(CMD_ALLOC, '0);
    push_word(CMD_FREE, OFFSET_W'(1));
    push_word(CMD_CLOSE, '0);

    // widest page size, count above built depth; top extent gives the widest alloc_offset
    wait_idle();
    write_reg(REG_PAGE_SIZE, '1);
    write_reg(REG_EXTENT_COUNT, PAGE_W'(2047));
    cfg_valid <= 1'b0;
    push_word(CMD_OPEN, '0);
    push_word(CMD_ALLOC, '0);
    push_word(CMD_FREE, OFFSET_W'(64'd1024 * 64'd2097151));
    push_word(CMD_ALLOC, '0);

    // random phases
    run_phase(PAGE_W'(4096), PAGE_W'(16), 250, 1'b0, 1'b1, 1'b0);
    run_phase(PAGE_W'(1), PAGE_W'(1), 250, 1'b1, 1'b0, 1'b0);
    run_phase(PAGE_W'(1048576), PAGE_W'(1024), 250, 1'b0, 1'b0, 1'b0);
    run_phase(PAGE_W'(3), PAGE_W'(5), 250, 1'b0, 1'b0, 1'b1);
    run_phase(PAGE_W'(0), PAGE_W'(3), 250, 1'b0, 1'b0, 1'b0);
    run_phase(PAGE_W'($urandom_range(1, 2097151)), PAGE_W'($urandom_range(1, 64)),
              250, 1'b1, 1'b0, 1'b0);
    run_phase(PAGE_W'(2097151), PAGE_W'(2047), 250, 1'b0, 1'b0, 1'b0);
    wait_idle();
    calm = 1'b1;
    run_phase(PAGE_W'($urandom_range(2, 64)), PAGE_W'(40), 250, 1'b0, 1'b0, 1'b0);

    wait_idle();
    repeat (64) @(posedge clk);
    if (reply_q.size() != 0)
      report_err($sformatf("%0d results never arrived", reply_q.size()));

    $display("covered %0d words: %0d allocate, %0d free, %0d open, %0d close; %0d reg writes",
             n_results, cmd_seen[CMD_ALLOC], cmd_seen[CMD_FREE], cmd_seen[CMD_OPEN],
             cmd_seen[CMD_CLOSE], n_settings);
    $display("status mix: ok %0d, no space %0d, not open %0d, bad offset %0d, double free %0d",
             stat_seen[STAT_OK], stat_seen[STAT_NO_SPACE], stat_seen[STAT_NOT_OPEN],
             stat_seen[STAT_BAD_OFFSET], stat_seen[STAT_DOUBLE_FREE]);
    if (errors == 0) begin
      $display("[extent_free_list_allocator] OK");
    end else begin
      $display("%0d errors", errors);
      $display("[extent_free_list_allocator] ERROR");
    end
    $finish;
  end

endmodule
